// ----- rtl/rth_pkg.sv -----
package rth_pkg;

    // Text fragments that a command can emit ahead of or after its plain byte
    typedef enum logic [2:0] {
        STR_NONE,
        STR_BSL,       // "\"
        STR_BSP,       // "\p"
        STR_BSPA,      // "\pa"
        STR_BR,        // "<br>\n"
        STR_BSQ,       // "\q"
        STR_CEN_OPEN,  // "<CENTER>"
        STR_CEN_CLOSE  // "</CENTER>"
    } str_id_t;

    // One classified input byte, as handed from the front to the back
    typedef struct packed {
        str_id_t    pre;
        logic       has_char;
        logic [7:0] ch;
        str_id_t    post;
        logic       term;
    } cmd_t;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int IDX_W      = 4;

    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_Q     = 8'h71;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;

    function automatic logic [IDX_W-1:0] str_len(str_id_t id);
        logic [IDX_W-1:0] n;
        unique case (id)
            STR_BSL:       n = IDX_W'(1);
            STR_BSP:       n = IDX_W'(2);
            STR_BSPA:      n = IDX_W'(3);
            STR_BR:        n = IDX_W'(5);
            STR_BSQ:       n = IDX_W'(2);
            STR_CEN_OPEN:  n = IDX_W'(8);
            STR_CEN_CLOSE: n = IDX_W'(9);
            default:       n = IDX_W'(0);
        endcase
        return n;
    endfunction

    // Byte idx of a fragment, counted from its first character
    function automatic logic [7:0] str_byte(str_id_t id, logic [IDX_W-1:0] idx);
        logic [71:0]      s;
        logic [IDX_W-1:0] pos;
        logic [6:0]       base;
        unique case (id)
            STR_BSL:       s = 72'("\\");
            STR_BSP:       s = 72'("\\p");
            STR_BSPA:      s = 72'("\\pa");
            STR_BR:        s = 72'("<br>\n");
            STR_BSQ:       s = 72'("\\q");
            STR_CEN_OPEN:  s = 72'("<CENTER>");
            STR_CEN_CLOSE: s = 72'("</CENTER>");
            default:       s = 72'd0;
        endcase
        pos  = str_len(id) - IDX_W'(1) - idx;
        base = {pos, 3'b000};
        return s[base +: 8];
    endfunction

endpackage

// ----- rtl/rth_front.sv -----
module rth_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    in_char,
    input  logic          in_last,
    output logic          wr,
    output rth_pkg::cmd_t cmd
);
    import rth_pkg::*;

    // escape match progress
    typedef enum logic [2:0] {
        M_IDLE,
        M_BSL,   // after "\"
        M_P,     // after "\p"
        M_PA,    // after "\pa"
        M_PAR,   // after "\par"
        M_Q      // after "\q"
    } match_t;

    match_t     match_reg, match_next;
    logic       cen_reg, cen_next;
    cmd_t       c;
    logic       do_plain;
    match_t     mid;

    always_comb
    begin
        c          = '0;
        c.pre      = STR_NONE;
        c.post     = STR_NONE;
        c.ch       = in_char;
        do_plain   = 1'b0;
        mid        = M_IDLE;
        cen_next   = cen_reg;
        unique case (match_reg)
            M_BSL:
            begin
                if (in_char == CH_P)
                    mid = M_P;
                else if (in_char == CH_Q)
                    mid = M_Q;
                else if (in_char == CH_SPACE || in_char == CH_NL)
                    mid = M_IDLE;
                else
                begin
                    c.pre    = STR_BSL;
                    do_plain = 1'b1;
                end
            end
            M_P:
            begin
                if (in_char == CH_A)
                    mid = M_PA;
                else
                begin
                    c.pre    = STR_BSP;
                    do_plain = 1'b1;
                end
            end
            M_PA:
            begin
                if (in_char == CH_R)
                    mid = M_PAR;
                else
                begin
                    c.pre    = STR_BSPA;
                    do_plain = 1'b1;
                end
            end
            M_PAR:
            begin
                if (in_char == CH_D)
                begin
                    if (cen_reg)
                        c.pre = STR_CEN_CLOSE;
                    cen_next = 1'b0;
                end
                else
                begin
                    c.pre    = STR_BR;
                    do_plain = 1'b1;
                end
            end
            M_Q:
            begin
                if (in_char == CH_C)
                begin
                    if (!cen_reg)
                        c.pre = STR_CEN_OPEN;
                    cen_next = 1'b1;
                end
                else
                begin
                    c.pre    = STR_BSQ;
                    do_plain = 1'b1;
                end
            end
            default: do_plain = 1'b1;
        endcase

        // ordinary byte: a backslash opens an escape, anything else passes
        if (do_plain)
        begin
            if (in_char == CH_BSL)
                mid = M_BSL;
            else
                c.has_char = 1'b1;
        end

        match_next = mid;
        if (in_last)
        begin
            unique case (mid)
                M_BSL:   c.post = STR_BSL;
                M_P:     c.post = STR_BSP;
                M_PA:    c.post = STR_BSPA;
                M_PAR:   c.post = STR_BR;
                M_Q:     c.post = STR_BSQ;
                default: c.post = STR_NONE;
            endcase
            c.term     = 1'b1;
            match_next = M_IDLE;
            cen_next   = 1'b0;
        end
    end

    assign cmd = c;
    // drop requests that produce no output
    assign wr  = accept && (c.pre != STR_NONE || c.has_char || c.term);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= M_IDLE;
            cen_reg   <= 1'b0;
        end
        else if (accept)
        begin
            match_reg <= match_next;
            cen_reg   <= cen_next;
        end
    end

endmodule

// ----- rtl/rth_fifo.sv -----
module rth_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  rth_pkg::cmd_t wdata,
    input  logic          rd,
    output rth_pkg::cmd_t rdata,
    output logic          full,
    output logic          nonempty
);
    import rth_pkg::*;

    cmd_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wp_reg, rp_reg;
    logic [FIFO_AW:0]   cnt_reg, cnt_next;

    assign full     = (cnt_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign nonempty = (cnt_reg != '0);
    assign rdata    = mem_reg[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr && !rd)
            cnt_next = cnt_reg + (FIFO_AW+1)'(1);
        else if (rd && !wr)
            cnt_next = cnt_reg - (FIFO_AW+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= wp_reg + FIFO_AW'(1);
            if (rd)
                rp_reg <= rp_reg + FIFO_AW'(1);
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- rtl/rth_back.sv -----
module rth_back (
    input  logic          clk,
    input  logic          rst_n,
    input  rth_pkg::cmd_t cmd,
    input  logic          cmd_valid,
    output logic          cmd_done,
    output logic [7:0]    out_char,
    output logic          out_last,
    output logic          empty,
    input  logic          pop
);
    import rth_pkg::*;

    typedef enum logic [1:0] {
        PH_PRE,
        PH_CHAR,
        PH_POST,
        PH_TERM
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_char_reg, out_char_next;
    logic             out_last_reg, out_last_next;

    phase_t     eff;
    logic       can_emit, phase_end, more;
    logic [3:0] present;

    always_comb
    begin
        present[PH_PRE]  = (cmd.pre != STR_NONE);
        present[PH_CHAR] = cmd.has_char;
        present[PH_POST] = (cmd.post != STR_NONE);
        present[PH_TERM] = cmd.term;

        // first phase at or after the held one that this command uses
        eff = PH_TERM;
        for (int i = 3; i >= 0; i--)
        begin
            if (2'(i) >= phase_reg && present[i])
                eff = phase_t'(2'(i));
        end
        more = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            if (2'(i) > eff && present[i])
                more = 1'b1;
        end

        out_char_next = out_char_reg;
        out_last_next = 1'b0;
        phase_end     = 1'b1;
        unique case (eff)
            PH_PRE:
            begin
                out_char_next = str_byte(cmd.pre, idx_reg);
                phase_end     = (idx_reg == str_len(cmd.pre) - IDX_W'(1));
            end
            PH_CHAR: out_char_next = cmd.ch;
            PH_POST:
            begin
                out_char_next = str_byte(cmd.post, idx_reg);
                phase_end     = (idx_reg == str_len(cmd.post) - IDX_W'(1));
            end
            default:
            begin
                out_char_next = 8'd0;
                out_last_next = 1'b1;
            end
        endcase

        can_emit = cmd_valid && (!out_valid_reg || pop);
        cmd_done = can_emit && phase_end && !more;

        phase_next = phase_reg;
        idx_next   = idx_reg;
        if (can_emit)
        begin
            if (!phase_end)
            begin
                phase_next = eff;
                idx_next   = idx_reg + IDX_W'(1);
            end
            else
            begin
                phase_next = more ? phase_t'(eff + 2'd1) : PH_PRE;
                idx_next   = '0;
            end
        end

        if (can_emit)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
        if (!can_emit)
        begin
            out_char_next = out_char_reg;
            out_last_next = out_last_reg;
        end
    end

    assign empty    = !out_valid_reg;
    assign out_char = out_char_reg;
    assign out_last = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_PRE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_char_reg  <= 8'd0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            out_char_reg  <= out_char_next;
            out_last_reg  <= out_last_next;
        end
    end

endmodule

// ----- rtl/rtf_subset_to_html_stream.sv -----
// A byte accepted at a clock edge is written into the command queue; the back end
// expands the head command into its single output register, one output byte per cycle
// while that register is empty or being popped, so plain text runs at one byte per
// cycle and "\pard" closing centering at end of text emits "</CENTER>" then a terminator;
// the input stalls only once the four-entry command queue is full.
// Reset (rst_n low, asynchronous): match state, centering flag, command queue and
// output register clear; no clearing pass is needed.
module rtf_subset_to_html_stream (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] in_char,
    input  logic       in_last,
    input  logic       push,
    output logic       full,
    output logic [7:0] out_char,
    output logic       out_last,
    output logic       empty,
    input  logic       pop
);
    import rth_pkg::*;

    logic accept;
    logic q_wr, q_full, q_nonempty, q_rd;
    cmd_t q_wdata, q_rdata;

    // Take a request whenever the command queue has room; the back end
    // drains the queue independently, so a stalled consumer only backs up
    // the input once the queue is full.
    assign full   = q_full;
    assign accept = push && !q_full;

    // Front: run the escape matcher and classify each byte into a command
    // (leading fragment, plain byte, trailing fragment, terminator).
    rth_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_char (in_char),
        .in_last (in_last),
        .wr      (q_wr),
        .cmd     (q_wdata)
    );

    // Queue: hold commands between classification and expansion.
    rth_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (q_wr),
        .wdata    (q_wdata),
        .rd       (q_rd),
        .rdata    (q_rdata),
        .full     (q_full),
        .nonempty (q_nonempty)
    );

    // Back: expand the head command one byte per cycle, while the output register is free or
    // being popped, into that register; advance the queue when its last byte is emitted.
    rth_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (q_rdata),
        .cmd_valid (q_nonempty),
        .cmd_done  (q_rd),
        .out_char  (out_char),
        .out_last  (out_last),
        .empty     (empty),
        .pop       (pop)
    );

endmodule
